FILE: hw/rtl/rgba8pp_pkg.sv
// Shared types, codes and helper functions for the RGBA8 pixel pack converter.
// Used by rgba8_pixel_pack_converter_core; depends on nothing else.
`default_nettype none

package rgba8pp_pkg;

  // Largest row length honoured; larger row_pixels values saturate here.
  localparam int unsigned MAX_DIMENSION = 8192;
  localparam int unsigned RP_W          = $clog2(MAX_DIMENSION + 1);
  // Row length times up to four bytes, plus alignment slack.
  localparam int unsigned STRIDE_W      = RP_W + 3;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  typedef enum logic [2:0] {
    FMT_ALPHA       = 3'd0,
    FMT_LUMINANCE   = 3'd1,
    FMT_LUM_ALPHA   = 3'd2,
    FMT_RGB         = 3'd3,
    FMT_RGBA        = 3'd4,
    FMT_BGR         = 3'd5,
    FMT_BGRA        = 3'd6,
    FMT_UNSUPPORTED = 3'd7
  } pix_fmt_e;

  typedef enum logic [2:0] {
    TYPE_UBYTE       = 3'd0,
    TYPE_565         = 3'd1,
    TYPE_4444        = 3'd2,
    TYPE_5551        = 3'd3,
    TYPE_4444_REV    = 3'd4,
    TYPE_1555_REV    = 3'd5,
    TYPE_8888_REV    = 3'd6,
    TYPE_UNSUPPORTED = 3'd7
  } pix_type_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ENUM = 2'd1,
    ERR_OP   = 2'd2
  } err_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_FORMAT   = 3'd0,
    REG_PIXEL_TYPE     = 3'd1,
    REG_SWAP_BYTES     = 3'd2,
    REG_TEXTURE_SOURCE = 3'd3,
    REG_ROW_PIXELS     = 3'd4,
    REG_ALIGN_SHIFT    = 3'd5,
    REG_SKIP_ROWS      = 3'd6,
    REG_SKIP_PIXELS    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic [12:0] pixel_row;
    logic [12:0] pixel_column;
  } in_item_t;

  typedef struct packed {
    logic [28:0] byte_offset;
    logic [31:0] packed_bytes;
    logic [2:0]  byte_count;
    logic [1:0]  error_code;
  } out_item_t;

  // Bytes per output pixel and the pair check.
  typedef struct packed {
    logic [2:0] size;
    err_e       err;
  } pix_size_t;

  function automatic pix_size_t pixel_size(pix_fmt_e fmt, pix_type_e typ, logic tex_src);
    pix_size_t  res;
    logic [2:0] comps;
    logic       fmt_ok;
    res    = '{size: 3'd0, err: ERR_NONE};
    comps  = 3'd0;
    fmt_ok = 1'b1;
    unique case (fmt)
      FMT_RGB, FMT_BGR:          comps = 3'd3;
      FMT_RGBA, FMT_BGRA:        comps = 3'd4;
      FMT_ALPHA, FMT_LUMINANCE: begin
        comps  = 3'd1;
        fmt_ok = tex_src;
      end
      FMT_LUM_ALPHA: begin
        comps  = 3'd2;
        fmt_ok = tex_src;
      end
      FMT_UNSUPPORTED:           fmt_ok = 1'b0;
    endcase
    if (!fmt_ok) begin
      res.err = ERR_ENUM;
    end else begin
      unique case (typ)
        TYPE_UBYTE: res.size = comps;
        TYPE_565: begin
          if (fmt == FMT_RGB) res.size = 3'd2;
          else                res.err  = ERR_OP;
        end
        TYPE_4444, TYPE_5551, TYPE_4444_REV, TYPE_1555_REV: begin
          if (comps == 3'd4) res.size = 3'd2;
          else               res.err  = ERR_OP;
        end
        TYPE_8888_REV: begin
          if (comps == 3'd4) res.size = 3'd4;
          else               res.err  = ERR_OP;
        end
        TYPE_UNSUPPORTED: res.err = ERR_ENUM;
      endcase
    end
    return res;
  endfunction

  // Store-order bytes for one pixel; unused upper bytes are zero.
  function automatic logic [31:0] pack_pixel(logic [31:0] rgba, pix_fmt_e fmt,
                                             pix_type_e typ, logic swap);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [15:0] v16;
    logic [31:0] res;
    r   = rgba[7:0];
    g   = rgba[15:8];
    b   = rgba[23:16];
    a   = rgba[31:24];
    v16 = 16'd0;
    res = 32'd0;
    if (fmt == FMT_BGR || fmt == FMT_BGRA) begin
      r = rgba[23:16];
      b = rgba[7:0];
    end
    unique case (typ)
      TYPE_UBYTE: begin
        unique case (fmt)
          FMT_ALPHA:         res = {24'd0, a};
          FMT_LUMINANCE:     res = {24'd0, r};
          FMT_LUM_ALPHA:     res = {16'd0, a, r};
          FMT_RGB, FMT_BGR:  res = {8'd0, b, g, r};
          FMT_RGBA, FMT_BGRA, FMT_UNSUPPORTED: res = {a, b, g, r};
        endcase
      end
      TYPE_565:      v16 = {r[7:3], g[7:2], b[7:3]};
      TYPE_4444:     v16 = {r[7:4], g[7:4], b[7:4], a[7:4]};
      TYPE_5551:     v16 = {r[7:3], g[7:3], b[7:3], a[7]};
      TYPE_4444_REV: v16 = {a[7:4], b[7:4], g[7:4], r[7:4]};
      TYPE_1555_REV: v16 = {a[7], b[7:3], g[7:3], r[7:3]};
      TYPE_8888_REV: res = swap ? {r, g, b, a} : {a, b, g, r};
      TYPE_UNSUPPORTED: res = 32'd0;
    endcase
    if (typ != TYPE_UBYTE && typ != TYPE_8888_REV && typ != TYPE_UNSUPPORTED) begin
      res = swap ? {16'd0, v16[7:0], v16[15:8]} : {16'd0, v16};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgba8_pixel_pack_converter_core.sv
// RGBA8 pixel pack converter: format/type check, packing and destination offset.
// Depends on rgba8pp_pkg for item structs, register codes and pack helpers.
// Input register, then result register; throughput 1 item/clock while the sink does not stall.
// The offset multiply (row times stride) sits between the two registers; the stride
// and pixel size come from a derived register refreshed every cycle from the config.
// Reset (async, active low) empties both stages and loads the config reset values.
`default_nettype none

module rgba8_pixel_pack_converter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire rgba8pp_pkg::in_item_t                in_data_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output rgba8pp_pkg::out_item_t                    out_data_o,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [rgba8pp_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [rgba8pp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  rgba8pp_pkg::pix_fmt_e  pixel_format_q;
  rgba8pp_pkg::pix_type_e pixel_type_q;
  logic                   swap_bytes_q;
  logic                   texture_source_q;
  logic [13:0]            row_pixels_q;
  logic [1:0]             align_shift_q;
  logic [12:0]            skip_rows_q;
  logic [12:0]            skip_pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q   <= rgba8pp_pkg::FMT_RGBA;
      pixel_type_q     <= rgba8pp_pkg::TYPE_UBYTE;
      swap_bytes_q     <= 1'b0;
      texture_source_q <= 1'b0;
      row_pixels_q     <= 14'd1;
      align_shift_q    <= 2'd2;
      skip_rows_q      <= 13'd0;
      skip_pixels_q    <= 13'd0;
    end else if (cfg_we_i) begin
      unique case (rgba8pp_pkg::cfg_reg_e'(cfg_index_i))
        rgba8pp_pkg::REG_PIXEL_FORMAT:
          pixel_format_q   <= rgba8pp_pkg::pix_fmt_e'(cfg_data_i[2:0]);
        rgba8pp_pkg::REG_PIXEL_TYPE:
          pixel_type_q     <= rgba8pp_pkg::pix_type_e'(cfg_data_i[2:0]);
        rgba8pp_pkg::REG_SWAP_BYTES:     swap_bytes_q     <= cfg_data_i[0];
        rgba8pp_pkg::REG_TEXTURE_SOURCE: texture_source_q <= cfg_data_i[0];
        rgba8pp_pkg::REG_ROW_PIXELS:     row_pixels_q     <= cfg_data_i[13:0];
        rgba8pp_pkg::REG_ALIGN_SHIFT:    align_shift_q    <= cfg_data_i[1:0];
        rgba8pp_pkg::REG_SKIP_ROWS:      skip_rows_q      <= cfg_data_i[12:0];
        rgba8pp_pkg::REG_SKIP_PIXELS:    skip_pixels_q    <= cfg_data_i[12:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived settings: pixel size, pair check and aligned row stride.
  // Config must only move while the block is idle (the block itself does not enforce
  // this), so the registered refresh is settled before the next item leaves the input register.
  // ---------------------------------------------------------------------------
  rgba8pp_pkg::pix_size_t                  psize_d, psize_q;
  logic [rgba8pp_pkg::RP_W-1:0]            rp;
  logic [2:0]                              align_mask;
  logic [rgba8pp_pkg::STRIDE_W-1:0]        rp_bytes;
  logic [rgba8pp_pkg::STRIDE_W-1:0]        stride_d, stride_q;

  always_comb begin
    psize_d = rgba8pp_pkg::pixel_size(pixel_format_q, pixel_type_q, texture_source_q);
    // row lengths beyond the maximum saturate
    if (32'(row_pixels_q) > 32'(rgba8pp_pkg::MAX_DIMENSION)) begin
      rp = rgba8pp_pkg::RP_W'(rgba8pp_pkg::MAX_DIMENSION);
    end else begin
      rp = rgba8pp_pkg::RP_W'(row_pixels_q);
    end
    align_mask = 3'((4'd1 << align_shift_q) - 4'd1);
    rp_bytes   = rgba8pp_pkg::STRIDE_W'(rp) * rgba8pp_pkg::STRIDE_W'(psize_d.size);
    stride_d   = (rp_bytes + rgba8pp_pkg::STRIDE_W'(align_mask))
               & ~rgba8pp_pkg::STRIDE_W'(align_mask);
  end

  always_ff @(posedge clk_i) begin
    psize_q  <= psize_d;
    stride_q <= stride_d;
  end

  // ---------------------------------------------------------------------------
  // Two-stage pipeline: input register -> result register.
  // Both stages advance together unless the result waits on a stalled sink;
  // an empty input stage still takes a new item during such a stall.
  // ---------------------------------------------------------------------------
  logic                    in_valid_q;
  rgba8pp_pkg::in_item_t   in_q;
  logic                    out_valid_q;
  rgba8pp_pkg::out_item_t  out_d, out_q;
  logic                    pipe_en;
  logic                    in_load;

  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_load    = pipe_en || !in_valid_q;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) in_valid_q  <= in_valid_i;
      if (pipe_en) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) in_q  <= in_data_i;
    if (pipe_en && in_valid_q) out_q <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Per-item work: pack the pixel and form the byte offset.
  // offset = (skip_rows + row) * stride + (skip_pixels + column) * size, mod 2^29
  // ---------------------------------------------------------------------------
  logic [13:0] row_sum;
  logic [13:0] col_sum;
  logic [30:0] row_bytes;
  logic [16:0] col_bytes;
  logic [28:0] offset;
  logic [31:0] packed_word;

  always_comb begin
    row_sum     = {1'b0, skip_rows_q} + {1'b0, in_q.pixel_row};
    col_sum     = {1'b0, skip_pixels_q} + {1'b0, in_q.pixel_column};
    row_bytes   = 31'(row_sum) * 31'(stride_q);
    col_bytes   = 17'(col_sum) * 17'(psize_q.size);
    offset      = row_bytes[28:0] + 29'(col_bytes);
    packed_word = rgba8pp_pkg::pack_pixel(in_q.pixel_rgba, pixel_format_q,
                                          pixel_type_q, swap_bytes_q);
    if (psize_q.err != rgba8pp_pkg::ERR_NONE) begin
      // rejected pair: no bytes, only the error code
      out_d.byte_offset  = 29'd0;
      out_d.packed_bytes = 32'd0;
      out_d.byte_count   = 3'd0;
    end else begin
      out_d.byte_offset  = offset;
      out_d.packed_bytes = packed_word;
      out_d.byte_count   = psize_q.size;
    end
    out_d.error_code = psize_q.err;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
